[rtl/core/hthpd_pkg.sv]
// Package for the heading to haptic pulse driver: word types, codes, constants
// and the interval table. No dependencies.
package hthpd_pkg;

   // Circle and dead zone, in 1/16 degree
   localparam int unsigned FULL_CIRCLE = 5760;
   localparam int unsigned DEAD_ZONE   = 96;

   localparam int unsigned MOTOR_COUNT_DEFAULT = 20;

   localparam int unsigned HEADING_W  = 13;
   localparam int unsigned MOTOR_W    = 5;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned DURATION_W = 16;
   localparam int unsigned POS_W      = 2;
   localparam int unsigned CSR_IDX_W  = 1;

   // Register reset values
   localparam logic [DURATION_W-1:0] ON_DURATION_RESET    = 16'd200;
   localparam logic [DURATION_W-1:0] START_INTERVAL_RESET = 16'd500;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ON_DURATION    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INTERVAL = 1'b1;

   // Commands
   localparam logic CMD_HEADING = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // Motor actions
   localparam logic [1:0] ACTION_NONE = 2'd0;
   localparam logic [1:0] ACTION_ON   = 2'd1;
   localparam logic [1:0] ACTION_OFF  = 2'd2;

   // Interval table, ms
   localparam logic [DURATION_W-1:0] INTERVAL_0 = 16'd500;
   localparam logic [DURATION_W-1:0] INTERVAL_1 = 16'd1500;
   localparam logic [DURATION_W-1:0] INTERVAL_2 = 16'd2500;
   localparam logic [DURATION_W-1:0] INTERVAL_3 = 16'd3500;

   typedef struct packed {
      logic                  command;
      logic [HEADING_W-1:0]  heading_sixteenths;
      logic [TIME_W-1:0]     now_ms;
      logic                  always_on;
   } req_type;

   typedef struct packed {
      logic                  ignored;
      logic [MOTOR_W-1:0]    motor_index;
      logic [1:0]            motor_action;
      logic                  released_valid;
      logic [MOTOR_W-1:0]    released_index;
      logic [DURATION_W-1:0] interval_ms;
   } rsp_type;

   // Snap result handed from the snap logic to the control
   typedef struct packed {
      logic               in_range;
      logic               far;
      logic [MOTOR_W-1:0] motor;
   } snap_type;

   function automatic logic [DURATION_W-1:0] interval_lookup(input logic [POS_W-1:0] pos);
      logic [DURATION_W-1:0] val;
      case (pos)
         2'd0:    val = INTERVAL_0;
         2'd1:    val = INTERVAL_1;
         2'd2:    val = INTERVAL_2;
         2'd3:    val = INTERVAL_3;
         default: val = INTERVAL_0;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/heading_to_haptic_pulse_driver_core.sv]
// Top level of the heading to haptic pulse driver: input register, result
// register, configuration registers. Depends on hthpd_pkg, hthpd_snap, hthpd_ctrl.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid, req_stall, req_data          | in
//   result  | rsp_valid, rsp_stall, rsp_data          | out
//   config  | csr_wr_en, csr_index, csr_wdata         | in
//
// One word per cycle sustained while rsp_stall is low; a taken request goes into the
// input register and its result then into the result register, built by the single
// snap and timing pass between them. Synchronous reset empties both registers and
// restores the motor state and register defaults. A stalled result holds while the
// input register still takes one more word.
module heading_to_haptic_pulse_driver_core #(
   parameter int unsigned MOTOR_COUNT = hthpd_pkg::MOTOR_COUNT_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  hthpd_pkg::req_type               req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output hthpd_pkg::rsp_type               rsp_data,
   input  logic                             csr_wr_en,
   input  logic [hthpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hthpd_pkg::DURATION_W-1:0] csr_wdata
);
   import hthpd_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   req_type               in_data_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_data_ff;
   logic [DURATION_W-1:0] on_dur_ff;
   logic [DURATION_W-1:0] start_int_ff;

   logic     req_take;
   logic     advance;
   snap_type snap;
   rsp_type  result;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   hthpd_snap #(
      .MOTOR_COUNT(MOTOR_COUNT)
   ) u_snap (
      .heading (in_data_ff.heading_sixteenths),
      .snap    (snap)
   );

   hthpd_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .item           (in_data_ff),
      .snap           (snap),
      .on_duration    (on_dur_ff),
      .start_interval (start_int_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         on_dur_ff    <= ON_DURATION_RESET;
         start_int_ff <= START_INTERVAL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ON_DURATION:    on_dur_ff    <= csr_wdata;
               CSR_START_INTERVAL: start_int_ff <= csr_wdata;
               default:            ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/core/hthpd_snap.sv]
// Heading snap: nearest motor, circular distance to its snap point, dead zone test.
// Depends on hthpd_pkg.
module hthpd_snap #(
   parameter int unsigned MOTOR_COUNT = hthpd_pkg::MOTOR_COUNT_DEFAULT
) (
   input  logic [hthpd_pkg::HEADING_W-1:0] heading,
   output hthpd_pkg::snap_type             snap
);
   import hthpd_pkg::*;

   localparam int unsigned STEP = FULL_CIRCLE / MOTOR_COUNT;
   localparam int unsigned HALF = STEP / 2;
   localparam int unsigned K_W  = $clog2(MOTOR_COUNT + 1);

   logic [HEADING_W:0]   rounded;
   logic [K_W-1:0]       k;
   logic [HEADING_W-1:0] point;
   logic [HEADING_W-1:0] gap;
   logic [HEADING_W-1:0] gap_alt;
   logic [HEADING_W-1:0] gap_min;

   assign rounded = {1'b0, heading} + (HEADING_W+1)'(HALF);

   // Thresholds are constants, so this is a row of parallel compares
   always_comb begin
      k     = '0;
      point = '0;
      for (int j = 1; j <= int'(MOTOR_COUNT); j++) begin
         if (rounded >= (HEADING_W+1)'(j * STEP)) begin
            k     = K_W'(j);
            point = HEADING_W'(j * STEP);
         end
      end
   end

   always_comb begin
      gap     = (heading >= point) ? (heading - point) : (point - heading);
      gap_alt = HEADING_W'(FULL_CIRCLE) - gap;
      gap_min = (gap > gap_alt) ? gap_alt : gap;
   end

   always_comb begin
      snap.in_range = (heading < HEADING_W'(FULL_CIRCLE));
      snap.far      = (gap_min > HEADING_W'(DEAD_ZONE));
      // k reaches MOTOR_COUNT only just below 360, which wraps to motor 0
      snap.motor    = (k == K_W'(MOTOR_COUNT)) ? '0 : MOTOR_W'(k);
   end

endmodule

[rtl/core/hthpd_ctrl.sv]
// Motor selection, release and pulse timing state; builds the result word.
// Depends on hthpd_pkg.
module hthpd_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  hthpd_pkg::req_type               item,
   input  hthpd_pkg::snap_type              snap,
   input  logic [hthpd_pkg::DURATION_W-1:0] on_duration,
   input  logic [hthpd_pkg::DURATION_W-1:0] start_interval,
   output hthpd_pkg::rsp_type               result
);
   import hthpd_pkg::*;

   logic                  have_dir_ff, have_dir_in;
   logic [MOTOR_W-1:0]    motor_ff, motor_in;
   logic [TIME_W-1:0]     start_ff, start_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  table_ff, table_in;

   logic [DURATION_W-1:0] interval_cur;
   logic [MOTOR_W-1:0]    motor_sel;
   logic                  change;
   logic [TIME_W-1:0]     start_eff;
   logic [TIME_W-1:0]     elapsed;
   logic [DURATION_W:0]   limit;

   assign interval_cur = table_ff ? interval_lookup(pos_ff) : start_interval;

   always_comb begin
      motor_sel = (have_dir_ff && snap.far) ? motor_ff : snap.motor;
      change    = !have_dir_ff || (motor_sel != motor_ff);
      start_eff = change ? item.now_ms : start_ff;
      elapsed   = item.now_ms - start_eff;
      limit     = {1'b0, on_duration} + {1'b0, interval_cur};
   end

   always_comb begin
      have_dir_in = have_dir_ff;
      motor_in    = motor_ff;
      start_in    = start_ff;
      pos_in      = pos_ff;
      table_in    = table_ff;

      result.ignored        = 1'b1;
      result.motor_index    = motor_ff;
      result.motor_action   = ACTION_NONE;
      result.released_valid = 1'b0;
      result.released_index = '0;
      result.interval_ms    = interval_cur;

      if (item.command == CMD_ADVANCE) begin
         pos_in             = pos_ff + POS_W'(1);
         table_in           = 1'b1;
         result.interval_ms = interval_lookup(pos_ff + POS_W'(1));
      end else if (snap.in_range) begin
         result.ignored     = 1'b0;
         have_dir_in        = 1'b1;
         motor_in           = motor_sel;
         result.motor_index = motor_sel;
         start_in           = start_eff;
         if (change) begin
            result.motor_action = ACTION_ON;
         end
         if (have_dir_ff && change) begin
            result.released_valid = 1'b1;
            result.released_index = motor_ff;
         end
         if (item.always_on || (elapsed >= TIME_W'(limit))) begin
            result.motor_action = ACTION_ON;
            start_in            = item.now_ms;
         end else if (elapsed >= TIME_W'(on_duration)) begin
            result.motor_action = ACTION_OFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_dir_ff <= 1'b0;
         motor_ff    <= '0;
         start_ff    <= '0;
         pos_ff      <= '0;
         table_ff    <= 1'b0;
      end else if (advance) begin
         have_dir_ff <= have_dir_in;
         motor_ff    <= motor_in;
         start_ff    <= start_in;
         pos_ff      <= pos_in;
         table_ff    <= table_in;
      end
   end

endmodule
